FILE: src/avcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcss_pkg: shared types and constants of the capture sync scheduler
// Item kinds, decision codes, register indexes, field widths and the request
// record that travels from the front stage through the queue to the back end.
// ----------------------------------------------------------------------------
package avcss_pkg;

   // fixed field widths
   localparam int FIELD_TIME_W = 40;
   localparam int TARGET_W     = 48;
   localparam int DUR_W        = 24;
   localparam int REP_W        = 8;
   localparam int BURST_W      = 4;
   localparam int WAIT_W       = 23;
   localparam int VT2_W        = FIELD_TIME_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_INDEX_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_DUR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REPEATS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUDIO_BURST = 2'd2;

   // register reset values
   localparam logic [DUR_W-1:0]   FRAME_DUR_RESET   = 24'd16667;
   localparam logic [REP_W-1:0]   MAX_REPEATS_RESET = 8'd3;
   localparam logic [BURST_W-1:0] AUDIO_BURST_RESET = 4'd5;

   typedef enum logic [1:0] {
      KIND_DECIDE  = 2'd0,
      KIND_VIDEO   = 2'd1,
      KIND_AUDIO   = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      DEC_NONE   = 3'd0,
      DEC_VIDEO  = 3'd1,
      DEC_AUDIO  = 3'd2,
      DEC_DROP   = 3'd3,
      DEC_REPEAT = 3'd4
   } decision_type;

   typedef struct packed {
      logic [DUR_W-1:0]   frame_dur;
      logic [REP_W-1:0]   max_repeats;
      logic [BURST_W-1:0] audio_burst;
   } cfg_type;

   // classified request as queued for the back end
   typedef struct packed {
      kind_type                kind;
      logic [FIELD_TIME_W-1:0] now_ticks;
      logic                    video_present;
      logic [FIELD_TIME_W-1:0] video_time;
      logic [VT2_W-1:0]        vt_2dur;     // video_time + 2 * frame period
      logic                    audio_present;
   } item_type;

endpackage

FILE: src/avcss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcss_front: request intake stage
// Registers each request, decodes its kind and adds the state-free part of
// the stale-frame bound, then hands the record to the queue.
// ----------------------------------------------------------------------------
module avcss_front
   import avcss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_kind,
   input  logic [FIELD_TIME_W-1:0] req_now,
   input  logic                    req_video_present,
   input  logic [FIELD_TIME_W-1:0] req_video_time,
   input  logic                    req_audio_present,
   output logic                    push,
   output item_type                push_item,
   input  logic                    queue_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // accept when the stage is empty or drains this cycle
   assign push       = valid_ff && !queue_full;
   assign req_tready = !valid_ff || !queue_full;
   assign push_item  = item_ff;

   // classify and precompute
   always_comb begin
      item_in.kind          = kind_type'(req_kind);
      item_in.now_ticks     = req_now;
      item_in.video_present = req_video_present;
      item_in.video_time    = req_video_time;
      item_in.vt_2dur       = VT2_W'(req_video_time) + VT2_W'({cfg.frame_dur, 1'b0});
      item_in.audio_present = req_audio_present;
      valid_in              = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the record while stalled
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: src/avcss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcss_queue: short request queue
// Two-entry FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module avcss_queue
   import avcss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  item_type          push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output item_type          head_item,
   output logic [QCNT_W-1:0] count
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/avcss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcss_back: scheduling back end
// Holds the timing state, decides on each request combinationally and places
// the decision and capped wait in the output register.
// ----------------------------------------------------------------------------
module avcss_back
   import avcss_pkg::*;
#(
   parameter int TIME_BITS = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              head_valid,
   input  item_type          head_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output decision_type      rsp_decision,
   output logic [WAIT_W-1:0] rsp_wait
);

   localparam int CW = (TIME_BITS > 50) ? TIME_BITS : 50;

   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TARGET_W-1:0]  target_ff, target_in;
   logic                 first_ff, first_in;
   decision_type         last_ff, last_in;
   logic [BURST_W-1:0]   arun_ff, arun_in;
   logic [REP_W-1:0]     rrun_ff, rrun_in;
   logic                 valid_ff, valid_in;
   decision_type         dec_ff, dec_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic [CW-1:0]        el_c, tgt_c, dur_c, tgt_new_c, diff_c;
   logic [TARGET_W:0]    tgt_sum;
   logic                 early, stale, ahead, late;
   decision_type         plain_dec, mixed_dec;
   logic                 mixed_inc;
   logic [WAIT_W-1:0]    cap;

   assign pop          = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid    = valid_ff;
   assign rsp_decision = dec_ff;
   assign rsp_wait     = wait_ff;

   // compares against the running target
   always_comb begin
      now_t   = TIME_BITS'(head_item.now_ticks);
      elapsed = (head_item.kind == KIND_RESTART) ? '0 : now_t - start_ff;
      el_c    = CW'(elapsed);
      tgt_c   = CW'(target_ff);
      dur_c   = CW'(cfg.frame_dur);
      early   = tgt_c > el_c;
      stale   = CW'(head_item.vt_2dur) < tgt_c;
      ahead   = CW'(head_item.video_time) > tgt_c + dur_c;
      late    = tgt_c + (dur_c << 1) < el_c;
      tgt_sum = (TARGET_W + 1)'(target_ff) + (TARGET_W + 1)'(cfg.frame_dur);
   end

   // frame choice: plain path without repeat limit
   always_comb begin
      priority if (early) begin
         plain_dec = DEC_NONE;
      end else if (!head_item.video_present) begin
         plain_dec = first_ff ? DEC_REPEAT : DEC_NONE;
      end else if (!first_ff) begin
         plain_dec = DEC_VIDEO;
      end else if (stale) begin
         plain_dec = DEC_DROP;
      end else if (ahead) begin
         plain_dec = DEC_REPEAT;
      end else begin
         plain_dec = DEC_VIDEO;
      end
   end

   // frame choice: mixed path, frame present, repeats counted
   always_comb begin
      mixed_inc = 1'b0;
      priority if (early) begin
         mixed_dec = DEC_NONE;
      end else if (stale) begin
         mixed_dec = DEC_DROP;
      end else if (ahead) begin
         if (rrun_ff >= cfg.max_repeats) begin
            mixed_dec = DEC_NONE;
         end else begin
            mixed_dec = DEC_REPEAT;
            mixed_inc = 1'b1;
         end
      end else begin
         mixed_dec = DEC_VIDEO;
      end
   end

   // state update and decision
   always_comb begin
      start_in  = start_ff;
      target_in = target_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      arun_in   = arun_ff;
      rrun_in   = rrun_ff;
      dec_in    = DEC_NONE;
      unique case (head_item.kind)
         KIND_RESTART: begin
            start_in  = now_t;
            target_in = '0;
            first_in  = 1'b0;
            last_in   = DEC_NONE;
            arun_in   = '0;
         end
         KIND_VIDEO: begin
            target_in = tgt_sum[TARGET_W] ? '1 : tgt_sum[TARGET_W-1:0];
            rrun_in   = '0;
            first_in  = 1'b1;
         end
         KIND_AUDIO: begin
            dec_in = DEC_NONE;
         end
         KIND_DECIDE: begin
            priority if (!first_ff && head_item.video_present) begin
               dec_in = DEC_VIDEO;
            end else if (!head_item.audio_present) begin
               dec_in = plain_dec;
            end else if (!head_item.video_present) begin
               if (arun_ff < cfg.audio_burst) begin
                  arun_in = arun_ff + 1'b1;
                  dec_in  = DEC_AUDIO;
               end
            end else if (late || arun_ff >= cfg.audio_burst) begin
               // forced frame: leave the last choice alone
               arun_in = '0;
               dec_in  = mixed_dec;
               if (mixed_inc) begin
                  rrun_in = rrun_ff + 1'b1;
               end
            end else if (last_ff == DEC_VIDEO) begin
               arun_in = arun_ff + 1'b1;
               last_in = DEC_AUDIO;
               dec_in  = DEC_AUDIO;
            end else begin
               dec_in  = mixed_dec;
               last_in = mixed_dec;
               if (mixed_inc) begin
                  rrun_in = rrun_ff + 1'b1;
               end
               if (mixed_dec == DEC_VIDEO) begin
                  arun_in = '0;
               end
            end
         end
      endcase
   end

   // wait until the next frame, capped at half a period
   always_comb begin
      tgt_new_c = CW'(target_in);
      diff_c    = tgt_new_c - el_c;
      cap       = cfg.frame_dur[DUR_W-1:1];
      wait_in   = '0;
      if (first_in && (tgt_new_c > el_c)) begin
         wait_in = (diff_c > CW'(cap)) ? cap : diff_c[WAIT_W-1:0];
      end
   end

   // output register valid
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         target_ff <= '0;
         first_ff  <= 1'b0;
         last_ff   <= DEC_NONE;
         arun_ff   <= '0;
         rrun_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            start_ff  <= start_in;
            target_ff <= target_in;
            first_ff  <= first_in;
            last_ff   <= last_in;
            arun_ff   <= arun_in;
            rrun_ff   <= rrun_in;
         end
      end
   end

   // load the response
   always_ff @(posedge clock) begin
      if (pop) begin
         dec_ff  <= dec_in;
         wait_ff <= wait_in;
      end
   end

endmodule

FILE: src/av_capture_sync_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av_capture_sync_scheduler: capture muxer sync scheduler
// Decides per request whether the muxer writes video, writes audio, drops a
// stale frame, repeats a frame or waits, and reports the capped frame wait.
//
//   channel  | direction | content
//   ---------+-----------+---------------------------------------------------
//   req_     | in        | tuser: kind; tdata: now, video flag, video time,
//            |           |        audio flag
//   rsp_     | out       | tdata: decision, wait_ticks
//   csr_     | in        | register index and write data
//
// One request per cycle sustained while the response side is not stalled; a
// response passes the intake register, then the queue, then the back end output
// register. The back end updates all timing state per request, so requests
// follow back to back. Reset loads the register defaults and clears all
// timing state.
// A stalled response holds; up to three requests are buffered behind it.
// ----------------------------------------------------------------------------
module av_capture_sync_scheduler
   import avcss_pkg::*;
#(
   parameter int TIME_BITS = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,  // [1:0] kind
   input  logic [87:0]            req_tdata,  // [39:0] now_ticks, [40] video_present,
                                              // [80:41] video_time, [81] audio_present
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // [2:0] decision, [25:3] wait_ticks
   // register write port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]       csr_data
);

   cfg_type           cfg_ff, cfg_in;
   logic              push, queue_full, head_valid, pop;
   item_type          push_item, head_item;
   logic [QCNT_W-1:0] q_count;
   decision_type      rsp_decision;
   logic [WAIT_W-1:0] rsp_wait;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_DUR:   cfg_in.frame_dur   = csr_data;
            CSR_MAX_REPEATS: cfg_in.max_repeats = csr_data[REP_W-1:0];
            CSR_AUDIO_BURST: cfg_in.audio_burst = csr_data[BURST_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_dur   <= FRAME_DUR_RESET;
         cfg_ff.max_repeats <= MAX_REPEATS_RESET;
         cfg_ff.audio_burst <= AUDIO_BURST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   avcss_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_kind          (req_tuser),
      .req_now           (req_tdata[39:0]),
      .req_video_present (req_tdata[40]),
      .req_video_time    (req_tdata[80:41]),
      .req_audio_present (req_tdata[81]),
      .push              (push),
      .push_item         (push_item),
      .queue_full        (queue_full)
   );

   avcss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (q_count)
   );

   avcss_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_decision (rsp_decision),
      .rsp_wait     (rsp_wait)
   );

   // pack the response
   assign rsp_tdata = {6'd0, rsp_wait, rsp_decision};

`ifndef SYNTHESIS
   a_wait_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_wait <= cfg_ff.frame_dur[DUR_W-1:1]))
      else $error("wait exceeds half a frame period");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      (q_count == '0) |-> req_tready)
      else $error("intake stalled with an empty queue");

   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && (head_item.kind == KIND_RESTART)) |=> (rsp_tdata[25:0] == '0))
      else $error("restart response not cleared");
`endif

endmodule

FILE: dv/tb_av_capture_sync_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_av_capture_sync_scheduler: self-checking bench for the sync scheduler
// A scoreboard class predicts the decision and the capped frame wait of every
// accepted request and compares each response against the oldest prediction.
// A directed opener walks the decision paths. Random phases follow under
// several register settings, including the period, repeat and burst extremes.
// Gaps on the request side and stalls on the response side come in bursts.
// ----------------------------------------------------------------------------
module tb_av_capture_sync_scheduler;
   import avcss_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      decision_type decision;
      logic [22:0]  wait_ticks;
   } sched_result_type;

   // Predicts the scheduler and checks its responses in order.
   class sync_scoreboard;
      logic [23:0]      frame_dur;
      logic [7:0]       max_rep;
      logic [3:0]       burst_lim;
      logic [39:0]      start_time;
      logic [47:0]      next_target;
      logic             first_done;
      decision_type     last_choice;
      logic [3:0]       audio_run;
      logic [7:0]       repeat_run;
      sched_result_type due_results[$];
      int               errors;
      int               n_requests;
      int               dec_seen[5];

      function new();
         frame_dur   = FRAME_DUR_RESET;
         max_rep     = MAX_REPEATS_RESET;
         burst_lim   = AUDIO_BURST_RESET;
         start_time  = '0;
         next_target = '0;
         first_done  = 1'b0;
         last_choice = DEC_NONE;
         audio_run   = '0;
         repeat_run  = '0;
         errors      = 0;
         n_requests  = 0;
         foreach (dec_seen[i]) dec_seen[i] = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // Apply a register write; an unused index is ignored.
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [23:0] data);
         case (idx)
            CSR_FRAME_DUR:   frame_dur = data;
            CSR_MAX_REPEATS: max_rep   = data[7:0];
            CSR_AUDIO_BURST: burst_lim = data[3:0];
            default: ;
         endcase
      endfunction

      // Frame choice shared by the video-only and the mixed path.
      function decision_type pick_frame(logic video, logic [39:0] vt,
                                        logic [39:0] elapsed, logic counted);
         logic [63:0] dur64;
         logic [63:0] vt64;
         logic [63:0] tgt64;
         dur64 = 64'(frame_dur);
         vt64  = 64'(vt);
         tgt64 = 64'(next_target);
         if (tgt64 > 64'(elapsed)) return DEC_NONE;
         if (!video) return first_done ? DEC_REPEAT : DEC_NONE;
         if (!first_done) return DEC_VIDEO;
         if (vt64 + 2 * dur64 < tgt64) return DEC_DROP;
         if (vt64 > tgt64 + dur64) begin
            if (!counted) return DEC_REPEAT;
            if (repeat_run >= max_rep) return DEC_NONE;
            repeat_run = repeat_run + 8'd1;
            return DEC_REPEAT;
         end
         return DEC_VIDEO;
      endfunction

      function decision_type decide_mix(logic video, logic [39:0] vt, logic audio,
                                        logic [39:0] elapsed);
         logic         late;
         decision_type d;
         // first frame goes out regardless of the mixed-path history
         if (!first_done && video) return DEC_VIDEO;
         if (!audio) return pick_frame(video, vt, elapsed, 1'b0);
         if (!video) begin
            if (audio_run < burst_lim) begin
               audio_run = audio_run + 4'd1;
               return DEC_AUDIO;
            end
            return DEC_NONE;
         end
         late = 64'(next_target) + 2 * 64'(frame_dur) < 64'(elapsed);
         // forced frame: late or burst used up, history left alone
         if (late || audio_run >= burst_lim) begin
            audio_run = '0;
            return pick_frame(1'b1, vt, elapsed, 1'b1);
         end
         if (last_choice == DEC_VIDEO) begin
            audio_run   = audio_run + 4'd1;
            last_choice = DEC_AUDIO;
            return DEC_AUDIO;
         end
         d = pick_frame(1'b1, vt, elapsed, 1'b1);
         last_choice = d;
         if (d == DEC_VIDEO) audio_run = '0;
         return d;
      endfunction

      // Advance the predicted state by one accepted request.
      function void note_request(kind_type k, logic [39:0] now, logic vp,
                                 logic [39:0] vt, logic ap);
         logic [39:0]      elapsed;
         logic [63:0]      sum;
         logic [47:0]      gap;
         logic [47:0]      cap;
         sched_result_type r;
         if (k == KIND_RESTART) begin
            start_time  = now;
            next_target = '0;
            first_done  = 1'b0;
            last_choice = DEC_NONE;
            audio_run   = '0;
         end
         elapsed    = now - start_time;
         r.decision = DEC_NONE;
         if (k == KIND_DECIDE) begin
            r.decision = decide_mix(vp, vt, ap, elapsed);
         end else if (k == KIND_VIDEO) begin
            sum = 64'(next_target) + 64'(frame_dur);
            next_target = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
            repeat_run  = '0;
            first_done  = 1'b1;
         end
         // wait reflects the state after this request
         r.wait_ticks = '0;
         if (first_done && 64'(next_target) > 64'(elapsed)) begin
            gap = next_target - 48'(elapsed);
            cap = 48'(frame_dur >> 1);
            if (gap > cap) gap = cap;
            r.wait_ticks = gap[22:0];
         end
         due_results.push_back(r);
         n_requests++;
      endfunction

      function void check_response(logic [31:0] data);
         sched_result_type r;
         if (due_results.size() == 0) begin
            $display("%0t: response with no request pending, got decision %0d wait %0d",
                     $time, data[2:0], data[25:3]);
            errors++;
            return;
         end
         r = due_results.pop_front();
         if (data[2:0] < 3'd5) dec_seen[data[2:0]]++;
         if (data[2:0] !== r.decision) begin
            $display("%0t: decision mismatch, expected %0d (%s) got %0d",
                     $time, r.decision, r.decision.name(), data[2:0]);
            errors++;
         end
         if (data[25:3] !== r.wait_ticks) begin
            $display("%0t: wait_ticks mismatch, expected %0d got %0d",
                     $time, r.wait_ticks, data[25:3]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser  = '0;
   logic [87:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [DUR_W-1:0]       csr_data   = '0;

   sync_scoreboard sb;
   bit  traffic_gaps = 1'b1;
   int  n_sent       = 0;
   int  stall_left   = 0;
   int  n_settings   = 1;

   av_capture_sync_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Stall the response side in short bursts, with quiet stretches.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (traffic_gaps && ((n_sent / 40) % 3 != 1) && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Observe every handshake on the three channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(kind_type'(req_tuser), req_tdata[39:0], req_tdata[40],
                            req_tdata[80:41], req_tdata[81]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // Present one request and hold it until taken.
   task automatic send_request(kind_type k, logic [39:0] now, logic vp,
                               logic [39:0] vt, logic ap);
      if (traffic_gaps && ((n_sent / 40) % 3 != 2) && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {6'b0, ap, vt, vp, now};
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (6) @(posedge clock);
   endtask

   // Write all three registers back to back, then poke the unused index.
   task automatic program_regs(logic [23:0] dur, logic [7:0] rep, logic [3:0] burst);
      logic [CSR_INDEX_W-1:0] idx[4];
      logic [23:0]            val[4];
      idx = '{CSR_FRAME_DUR, CSR_MAX_REPEATS, CSR_AUDIO_BURST, CSR_UNUSED};
      val = '{dur, {16'($urandom), rep}, {20'($urandom), burst}, 24'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // Random requests, mostly aimed around the predicted frame target.
   task automatic run_phase(int count);
      longint      span;
      longint      now_l;
      longint      vt_l;
      int          roll;
      kind_type    k;
      logic        vp;
      logic        ap;
      logic [39:0] now_v;
      logic [39:0] vt_v;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         span = (sb.frame_dur == 0) ? 64 : longint'(sb.frame_dur);
         if (roll < 10) begin
            // noise: any field value at all
            k     = kind_type'($urandom_range(0, 3));
            now_v = {8'($urandom), $urandom};
            vt_v  = {8'($urandom), $urandom};
            vp    = 1'($urandom);
            ap    = 1'($urandom);
         end else begin
            if (roll < 62)      k = KIND_DECIDE;
            else if (roll < 80) k = KIND_VIDEO;
            else if (roll < 92) k = KIND_AUDIO;
            else                k = KIND_RESTART;
            now_l = longint'(sb.start_time) + longint'(sb.next_target)
                    + longint'($urandom_range(0, 32'(6 * span))) - 2 * span;
            vt_l  = longint'(sb.next_target)
                    + longint'($urandom_range(0, 32'(6 * span))) - 3 * span;
            now_v = now_l[39:0];
            vt_v  = vt_l[39:0];
            vp    = $urandom_range(0, 3) != 0;
            ap    = 1'($urandom);
         end
         send_request(k, now_v, vp, vt_v, ap);
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk through the decision paths at reset settings
      send_request(KIND_DECIDE, 40'd0, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd10, 1'b0, 40'd0, 1'b1);
      send_request(KIND_DECIDE, 40'd20, 1'b1, 40'd0, 1'b0);
      send_request(KIND_VIDEO, 40'd100, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd20000, 1'b1, 40'd16667, 1'b0);
      send_request(KIND_VIDEO, 40'd20000, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd40000, 1'b1, 40'd60000, 1'b0);
      send_request(KIND_DECIDE, 40'd40000, 1'b0, 40'd0, 1'b0);
      send_request(KIND_VIDEO, 40'd40000, 1'b0, 40'd0, 1'b0);
      send_request(KIND_VIDEO, 40'd40000, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd70000, 1'b1, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd70000, 1'b1, 40'd66668, 1'b1);
      send_request(KIND_DECIDE, 40'd70000, 1'b1, 40'd66668, 1'b1);
      // counted repeats up to the limit, then none
      repeat (4) send_request(KIND_DECIDE, 40'd70000, 1'b1, 40'd200000, 1'b1);
      send_request(KIND_DECIDE, 40'd1000000, 1'b1, 40'd66668, 1'b1);
      repeat (6) send_request(KIND_DECIDE, 40'd1000000, 1'b0, 40'd0, 1'b1);
      send_request(KIND_AUDIO, '1, 1'b1, '1, 1'b1);
      // restart ahead of the clock so elapsed wraps
      send_request(KIND_RESTART, 40'd5, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, 40'd0, 1'b1, 40'd0, 1'b1);
      send_request(KIND_VIDEO, 40'd0, 1'b0, 40'd0, 1'b0);
      send_request(KIND_DECIDE, '1, 1'b1, '1, 1'b1);
      send_request(KIND_RESTART, '1, 1'b1, '1, 1'b1);
      run_phase(140);
      settle();

      program_regs(24'd1, 8'd0, 4'd0);
      run_phase(140);
      settle();

      program_regs(24'hFF_FFFF, 8'd255, 4'd15);
      run_phase(140);
      settle();

      // zero frame period
      program_regs(24'd0, 8'd1, 4'd1);
      run_phase(140);
      settle();

      program_regs(24'($urandom_range(1000, 40000)), 8'($urandom), 4'($urandom));
      run_phase(140);
      settle();

      // closing stretch at full rate on both sides
      program_regs(24'd16667, 8'd3, 4'd5);
      traffic_gaps = 1'b0;
      run_phase(140);
      settle();

      $display("Covered %0d requests under %0d register settings", sb.n_requests, n_settings);
      $display("Decisions seen: none %0d, video %0d, audio %0d, drop %0d, repeat %0d",
               sb.dec_seen[0], sb.dec_seen[1], sb.dec_seen[2], sb.dec_seen[3],
               sb.dec_seen[4]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop if the handshakes hang.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
